@@ rtl/core/aes_pkg.sv @@
// AES-128 core package: state machine type, register indexes, S-box tables
// and round helper functions. No dependencies.
package aes_pkg;

  localparam int unsigned KEY_W = 64;
  localparam int unsigned BLK_W = 128;

  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW  = 1'b1;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_FIRST,
    ST_ROUND,
    ST_DONE
  } state_t;

  typedef logic [7:0] byte_t;

  function automatic byte_t sbox_fwd(input byte_t a);
    byte_t tbl [0:255];
    tbl = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };
    return tbl[a];
  endfunction

  function automatic byte_t sbox_inv(input byte_t a);
    byte_t tbl [0:255];
    tbl = '{
      8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
      8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
      8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
      8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
      8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
      8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
      8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
      8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
      8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
      8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
      8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
      8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
      8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
      8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
      8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
    };
    return tbl[a];
  endfunction

  function automatic byte_t xtime(input byte_t v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
  endfunction

  // byte k of a 128-bit block, byte 0 in the top bits
  function automatic byte_t blk_byte(input logic [127:0] b, input int k);
    return b[127-8*k -: 8];
  endfunction

  // one full encryption round minus key add; last skips MixColumns
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    byte_t t [16];
    byte_t a0, a1, a2, a3;
    logic [127:0] r;
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++)
        t[4*c+w] = sbox_fwd(blk_byte(s, 4*((c+w)%4)+w));
    if (!last)
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        t[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        t[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        t[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        t[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    for (int k = 0; k < 16; k++) r[127-8*k -: 8] = t[k];
    return r;
  endfunction

  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] r;
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++)
        r[127-8*(4*c+w) -: 8] = sbox_inv(blk_byte(s, 4*((c+4-w)%4)+w));
    return r;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    byte_t a [4];
    byte_t x2 [4];
    byte_t x4 [4];
    byte_t x8 [4];
    byte_t m9 [4];
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        a[w]  = blk_byte(s, 4*c+w);
        x2[w] = xtime(a[w]);
        x4[w] = xtime(x2[w]);
        x8[w] = xtime(x4[w]);
        m9[w] = x8[w] ^ a[w];
      end
      // rows use coefficients 0E 0B 0D 09 rotated
      for (int w = 0; w < 4; w++)
        r[127-8*(4*c+w) -: 8] =
          (x8[w] ^ x4[w] ^ x2[w]) ^
          (m9[(w+1)%4] ^ x2[(w+1)%4]) ^
          (m9[(w+2)%4] ^ x4[(w+2)%4]) ^
          m9[(w+3)%4];
    end
    return r;
  endfunction

  // next round key from previous one and round constant
  function automatic logic [127:0] next_key(input logic [127:0] k, input byte_t rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {sbox_fwd(w3[23:16]) ^ rc, sbox_fwd(w3[15:8]), sbox_fwd(w3[7:0]),
         sbox_fwd(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

@@ rtl/core/aes128_block_cipher_core.sv @@
// AES-128 ECB core: key registers, round key expansion into a RAM, one round
// per cycle. Depends on aes_pkg and aes_ram.
//
//  channel | ports                              | handshake
//  input   | in_operation, in_data_high/low     | start & !busy & !cfg_we
//  result  | out_result_high/low                | out_valid, one cycle
//  config  | cfg_we, cfg_index, cfg_wdata       | cfg_we
//
// A block passes through ST_FIRST for the whitening key add, ST_ROUND for one
// round per cycle through the single round unit, and ST_DONE to present the
// result beat. busy drops with the edge that takes the result beat, so the
// next start is taken in the cycle after the beat at the earliest. A key write
// while idle or expanding starts an expansion pass, one RAM entry per cycle,
// during which busy is high; a key write during the pass restarts it. The
// receiver cannot stall. Reset is synchronous, active low.
module aes128_block_cipher_core #(
  parameter int unsigned ROUND_COUNT = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [63:0] in_data_high,
  input  logic [63:0] in_data_low,
  output logic        out_valid,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata
);
  import aes_pkg::*;

  localparam int unsigned ENTRIES = ROUND_COUNT + 1;
  localparam int unsigned AW = $clog2(ENTRIES);

  state_t state_r, state_nxt;
  logic [63:0]  key_high_r, key_low_r;
  logic [127:0] exp_key_r, exp_key_nxt;
  byte_t        rcon_r, rcon_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic         op_r, op_nxt;
  logic [127:0] blk_r, blk_nxt;
  logic [127:0] res_r, res_nxt;
  logic         valid_r, valid_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [127:0]  ram_wdata, rkey;
  logic          accept;
  logic [127:0]  enc_nxt, dec_nxt;
  logic          last_rnd;

  aes_ram #(.WIDTH(BLK_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(rkey)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign last_rnd = (cnt_r == AW'(ROUND_COUNT));

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_KEY_HIGH) key_high_r <= cfg_wdata;
      else key_low_r <= cfg_wdata;
    end
  end

  // round datapath
  assign enc_nxt = enc_round(blk_r, last_rnd) ^ rkey;
  always_comb begin
    dec_nxt = inv_shift_sub(blk_r) ^ rkey;
    if (!last_rnd) dec_nxt = inv_mix(dec_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
    exp_key_r <= exp_key_nxt;
    rcon_r    <= rcon_nxt;
    op_r      <= op_nxt;
    blk_r     <= blk_nxt;
    res_r     <= res_nxt;
  end

  // sequencer: expansion pass and round loop
  always_comb begin
    state_nxt   = state_r;
    exp_key_nxt = exp_key_r;
    rcon_nxt    = rcon_r;
    cnt_nxt     = cnt_r;
    op_nxt      = op_r;
    blk_nxt     = blk_r;
    res_nxt     = res_r;
    valid_nxt   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = cnt_r;
    ram_wdata   = exp_key_r;
    ram_raddr   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (cfg_we) begin
          state_nxt   = ST_EXPAND;
          cnt_nxt     = '0;
          rcon_nxt    = 8'h01;
          exp_key_nxt = (cfg_index == CFG_KEY_HIGH) ? {cfg_wdata, key_low_r}
                                                    : {key_high_r, cfg_wdata};
        end else if (accept) begin
          state_nxt = ST_FIRST;
          op_nxt    = in_operation;
          blk_nxt   = {in_data_high, in_data_low};
          ram_raddr = (in_operation == OP_DECRYPT) ? AW'(ROUND_COUNT) : '0;
        end
      end
      ST_EXPAND: begin
        ram_we      = 1'b1;
        exp_key_nxt = next_key(exp_key_r, rcon_r);
        rcon_nxt    = xtime(rcon_r);
        cnt_nxt     = cnt_r + AW'(1);
        if (cnt_r == AW'(ROUND_COUNT)) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end
        // new key write mid-pass: start over from the updated key
        if (cfg_we) begin
          state_nxt   = ST_EXPAND;
          cnt_nxt     = '0;
          rcon_nxt    = 8'h01;
          exp_key_nxt = (cfg_index == CFG_KEY_HIGH) ? {cfg_wdata, key_low_r}
                                                    : {key_high_r, cfg_wdata};
        end
      end
      ST_FIRST: begin
        // whitening key add, fetch first round key
        blk_nxt   = blk_r ^ rkey;
        cnt_nxt   = AW'(1);
        ram_raddr = (op_r == OP_DECRYPT) ? AW'(ROUND_COUNT - 1) : AW'(1);
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        blk_nxt   = (op_r == OP_DECRYPT) ? dec_nxt : enc_nxt;
        cnt_nxt   = cnt_r + AW'(1);
        ram_raddr = (op_r == OP_DECRYPT) ? AW'(ROUND_COUNT - 1) - cnt_r
                                         : cnt_r + AW'(1);
        if (last_rnd) begin
          state_nxt = ST_DONE;
          res_nxt   = blk_nxt;
          valid_nxt = 1'b1;
          cnt_nxt   = '0;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid       = valid_r;
  assign out_result_high = res_r[127:64];
  assign out_result_low  = res_r[63:0];

  // checks
  a_valid_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result beat longer than a cycle");
  a_valid_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == ST_DONE) else $error("result outside done");
  a_round_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROUND |-> cnt_r != '0 && cnt_r <= AW'(ROUND_COUNT))
    else $error("round counter out of range");
  a_exp_ram: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == ST_EXPAND) else $error("key ram written outside expand");
endmodule

@@ rtl/core/aes_ram.sv @@
// Generic single-port-write, registered-read RAM.
// No dependencies.
module aes_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 11
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
